@@ design/fpp_pkg.sv @@
`default_nettype none
package fpp_pkg;
    localparam int COUNTER_BITS = 16;
    localparam int NUM_PIECES = 12;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [COUNTER_BITS-1:0] cnt_t;

    typedef enum logic [2:0] {
        PH_BOARD, PH_TURN, PH_CASTLE_START, PH_CASTLE_BODY,
        PH_EP_FIRST, PH_EP_SECOND, PH_HALF, PH_FULL
    } phase_t;

    // classified beat passed from front to back
    typedef struct packed {
        logic       eot;
        logic [7:0] ch;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_piece;
        logic [3:0] piece;
    } beat_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_B     = 8'h62;

    function automatic logic [4:0] piece_code(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            unique case (c)
                8'h4b: r = {1'b1, 4'd0};
                8'h51: r = {1'b1, 4'd1};
                8'h52: r = {1'b1, 4'd2};
                8'h42: r = {1'b1, 4'd3};
                8'h4e: r = {1'b1, 4'd4};
                8'h50: r = {1'b1, 4'd5};
                8'h6b: r = {1'b1, 4'd6};
                8'h71: r = {1'b1, 4'd7};
                8'h72: r = {1'b1, 4'd8};
                8'h62: r = {1'b1, 4'd9};
                8'h6e: r = {1'b1, 4'd10};
                8'h70: r = {1'b1, 4'd11};
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

@@ design/fpp_front.sv @@
`default_nettype none
module fpp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    char_code,
    input  wire logic          end_of_text,
    input  wire logic          in_valid,
    output logic               in_ready,
    output fpp_pkg::beat_t     q_data,
    output logic               q_valid,
    input  wire logic          q_ready
);
    import fpp_pkg::*;

    beat_t            mem [QUEUE_DEPTH];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    beat_t            cls;
    logic [4:0]       pc;
    logic             push, pop;

    always_comb
    begin
        pc           = piece_code(char_code);
        cls.eot      = end_of_text;
        cls.ch       = char_code;
        cls.is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        cls.digit    = 4'(char_code - CH_ZERO);
        cls.is_piece = pc[4];
        cls.piece    = pc[3:0];
    end

    assign in_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

@@ design/fpp_back.sv @@
`default_nettype none
module fpp_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire fpp_pkg::beat_t             q_data,
    input  wire logic                       q_valid,
    output logic                            q_ready,
    output logic [3:0]                      piece_index,
    output logic [63:0]                     piece_board,
    output logic                            side_to_move,
    output logic [3:0]                      castling_rights,
    output logic                            ep_present,
    output logic [5:0]                      ep_square,
    output logic [fpp_pkg::COUNTER_BITS-1:0] halfmove_count,
    output logic [fpp_pkg::COUNTER_BITS-1:0] fullmove_count,
    output logic                            valid_res,
    output logic                            last,
    output logic                            out_valid,
    input  wire logic                       out_ready
);
    import fpp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  file_reg, file_next;
    logic [2:0]  rank_reg, rank_next;
    logic [63:0] boards_reg [NUM_PIECES];
    logic        set_en;
    logic [5:0]  set_sq;
    logic        turn_reg, turn_next;
    logic [3:0]  castle_reg, castle_next;
    logic        epf_reg, epf_next;
    logic [5:0]  ep_reg, ep_next;
    cnt_t        half_reg, half_next, full_reg, full_next;
    logic        dseen_reg, dseen_next;
    logic        err_reg, err_next;
    // burst snapshot
    logic [63:0] snap_reg [NUM_PIECES];
    logic        busy_reg;
    logic [3:0]  idx_reg;
    logic        good_reg;
    logic        s_turn_reg, s_epf_reg;
    logic [3:0]  s_castle_reg;
    logic [5:0]  s_ep_reg;
    cnt_t        s_half_reg, s_full_reg;
    logic        take, fin, done_beat;
    logic [4:0]  fsum;
    logic [3:0]  cb;

    function automatic cnt_t cnt_add(input cnt_t acc, input logic [3:0] d);
        logic [COUNTER_BITS+4:0] v;
        begin
            v = {acc, 3'b000} + {2'b00, acc, 1'b0} + (COUNTER_BITS+5)'(d);
            if (v > (COUNTER_BITS+5)'({COUNTER_BITS{1'b1}})) return '1;
            return v[COUNTER_BITS-1:0];
        end
    endfunction

    // an end beat waits while a burst is still draining
    assign q_ready   = !(busy_reg && q_data.eot);
    assign take      = q_valid && q_ready;
    assign fin       = take && q_data.eot;
    assign done_beat = busy_reg && out_ready && (last || !good_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        file_next   = file_reg;
        rank_next   = rank_reg;
        turn_next   = turn_reg;
        castle_next = castle_reg;
        epf_next    = epf_reg;
        ep_next     = ep_reg;
        half_next   = half_reg;
        full_next   = full_reg;
        dseen_next  = dseen_reg;
        err_next    = err_reg;
        set_en      = 1'b0;
        set_sq      = {rank_reg, file_reg[2:0]};
        fsum        = {1'b0, file_reg} + {1'b0, q_data.digit};
        cb          = 4'd0;
        unique case (q_data.ch)
            8'h4b: cb = 4'b0001;
            8'h51: cb = 4'b0010;
            8'h6b: cb = 4'b0100;
            8'h71: cb = 4'b1000;
            default: cb = 4'd0;
        endcase
        if (take && !q_data.eot && !err_reg)
        begin
            unique case (phase_reg)
                PH_BOARD:
                begin
                    if (q_data.ch >= CH_ONE && q_data.ch <= CH_EIGHT)
                    begin
                        if (fsum > 5'd8) err_next = 1'b1;
                        else file_next = fsum[3:0];
                    end
                    else if (q_data.ch == CH_SPACE)
                    begin
                        if (file_reg == 4'd8) phase_next = PH_TURN;
                        else if (!(file_reg == 4'd0 && rank_reg == 3'd7)) err_next = 1'b1;
                    end
                    else if (q_data.ch == CH_SLASH)
                    begin
                        if (file_reg != 4'd8 || rank_reg == 3'd0) err_next = 1'b1;
                        else
                        begin
                            file_next = 4'd0;
                            rank_next = rank_reg - 3'd1;
                        end
                    end
                    else if (q_data.is_piece)
                    begin
                        if (file_reg >= 4'd8) err_next = 1'b1;
                        else
                        begin
                            set_en    = 1'b1;
                            file_next = file_reg + 4'd1;
                        end
                    end
                    else err_next = 1'b1;
                end
                PH_TURN:
                begin
                    if (q_data.ch == CH_W)
                    begin
                        turn_next = 1'b0;
                        phase_next = PH_CASTLE_START;
                    end
                    else if (q_data.ch == CH_B)
                    begin
                        turn_next = 1'b1;
                        phase_next = PH_CASTLE_START;
                    end
                    else if (q_data.ch != CH_SPACE) err_next = 1'b1;
                end
                PH_CASTLE_START, PH_CASTLE_BODY:
                begin
                    if (q_data.ch == CH_SPACE)
                    begin
                        if (phase_reg == PH_CASTLE_BODY) phase_next = PH_EP_FIRST;
                    end
                    else if (q_data.ch == CH_DASH) phase_next = PH_EP_FIRST;
                    else if (cb == 4'd0) err_next = 1'b1;
                    else
                    begin
                        castle_next = castle_reg | cb;
                        phase_next  = PH_CASTLE_BODY;
                    end
                end
                PH_EP_FIRST:
                begin
                    if (q_data.ch == CH_DASH)
                    begin
                        epf_next = 1'b0;
                        phase_next = PH_HALF;
                    end
                    else if (q_data.ch >= CH_A && q_data.ch <= CH_H)
                    begin
                        ep_next = {3'd0, 3'(q_data.ch - CH_A)};
                        phase_next = PH_EP_SECOND;
                    end
                    else if (q_data.ch != CH_SPACE) err_next = 1'b1;
                end
                PH_EP_SECOND:
                begin
                    if (q_data.ch >= CH_ONE && q_data.ch <= CH_EIGHT)
                    begin
                        ep_next = {3'(q_data.ch - CH_ONE), ep_reg[2:0]};
                        epf_next = 1'b1;
                        phase_next = PH_HALF;
                    end
                    else err_next = 1'b1;
                end
                PH_HALF, PH_FULL:
                begin
                    if (q_data.ch == CH_SPACE)
                    begin
                        if (dseen_reg)
                        begin
                            if (phase_reg == PH_FULL) err_next = 1'b1;
                            else
                            begin
                                dseen_next = 1'b0;
                                phase_next = PH_FULL;
                            end
                        end
                    end
                    else if (q_data.is_digit)
                    begin
                        dseen_next = 1'b1;
                        if (phase_reg == PH_HALF) half_next = cnt_add(half_reg, q_data.digit);
                        else full_next = cnt_add(full_reg, q_data.digit);
                    end
                    else err_next = 1'b1;
                end
                default: err_next = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_BOARD;
            file_reg   <= 4'd0;
            rank_reg   <= 3'd7;
            turn_reg   <= 1'b0;
            castle_reg <= 4'd0;
            epf_reg    <= 1'b0;
            ep_reg     <= 6'd0;
            half_reg   <= '0;
            full_reg   <= '0;
            dseen_reg  <= 1'b0;
            err_reg    <= 1'b0;
            busy_reg   <= 1'b0;
            idx_reg    <= 4'd0;
            for (int i = 0; i < NUM_PIECES; i++) boards_reg[i] <= 64'd0;
        end
        else if (fin)
        begin
            phase_reg  <= PH_BOARD;
            file_reg   <= 4'd0;
            rank_reg   <= 3'd7;
            turn_reg   <= 1'b0;
            castle_reg <= 4'd0;
            epf_reg    <= 1'b0;
            ep_reg     <= 6'd0;
            half_reg   <= '0;
            full_reg   <= '0;
            dseen_reg  <= 1'b0;
            err_reg    <= 1'b0;
            busy_reg   <= 1'b1;
            idx_reg    <= 4'd0;
            for (int i = 0; i < NUM_PIECES; i++) boards_reg[i] <= 64'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            file_reg   <= file_next;
            rank_reg   <= rank_next;
            turn_reg   <= turn_next;
            castle_reg <= castle_next;
            epf_reg    <= epf_next;
            ep_reg     <= ep_next;
            half_reg   <= half_next;
            full_reg   <= full_next;
            dseen_reg  <= dseen_next;
            err_reg    <= err_next;
            if (set_en) boards_reg[q_data.piece][set_sq] <= 1'b1;
            if (done_beat) busy_reg <= 1'b0;
            else if (busy_reg && out_ready) idx_reg <= idx_reg + 4'd1;
        end
    end

    // snapshot of the finished position, read out one board per beat
    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            good_reg     <= !err_reg && phase_reg == PH_FULL && dseen_reg;
            snap_reg     <= boards_reg;
            s_turn_reg   <= turn_reg;
            s_castle_reg <= castle_reg;
            s_epf_reg    <= epf_reg;
            s_ep_reg     <= epf_reg ? ep_reg : 6'd0;
            s_half_reg   <= half_reg;
            s_full_reg   <= full_reg;
        end
    end

    assign out_valid       = busy_reg;
    assign valid_res       = good_reg;
    assign last            = !good_reg || idx_reg == 4'(NUM_PIECES - 1);
    assign piece_index     = good_reg ? idx_reg : 4'd0;
    assign piece_board     = good_reg ? snap_reg[idx_reg] : 64'd0;
    assign side_to_move    = good_reg & s_turn_reg;
    assign castling_rights = good_reg ? s_castle_reg : 4'd0;
    assign ep_present      = good_reg & s_epf_reg;
    assign ep_square       = good_reg ? s_ep_reg : 6'd0;
    assign halfmove_count  = good_reg ? s_half_reg : '0;
    assign fullmove_count  = good_reg ? s_full_reg : '0;
endmodule
`default_nettype wire

@@ design/fen_position_parser.sv @@
// fen position parser
// input channel: one text byte per beat (char_code), or an end beat
// (end_of_text = 1, char_code ignored), under in_valid / in_ready.
// output channel: result beats under out_valid / out_ready. a good text
// gives twelve beats, piece_index 0..11, last on the twelfth; a bad text
// gives one beat with valid_res 0, last 1, all else zero.
// throughput: one text byte per cycle while in_ready is high; the end beat
// starts a burst of twelve beats (or one), one per cycle while out_ready is
// high. text bytes of the next string keep flowing during the burst; its end
// beat waits until the burst has drained.
// a byte passes through a two-entry queue into the parse state; the first
// result beat shows at the edge where the end beat leaves the queue.
// reset: empty queue, parse state back to the start of the board field.
// a stalled receiver holds the current result beat; text bytes keep flowing
// until the next end beat reaches the queue head, then the queue fills and
// in_ready drops.
`default_nettype none
module fen_position_parser (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [7:0]                  char_code,
    input  wire logic                        end_of_text,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    output logic [3:0]                       piece_index,
    output logic [63:0]                      piece_board,
    output logic                             side_to_move,
    output logic [3:0]                       castling_rights,
    output logic                             ep_present,
    output logic [5:0]                       ep_square,
    output logic [fpp_pkg::COUNTER_BITS-1:0] halfmove_count,
    output logic [fpp_pkg::COUNTER_BITS-1:0] fullmove_count,
    output logic                             valid_res,
    output logic                             last,
    output logic                             out_valid,
    input  wire logic                        out_ready
);
    import fpp_pkg::*;

    beat_t q_data;
    logic  q_valid, q_ready;

    // front: classify bytes into the queue
    fpp_front u_front (
        .clk(clk), .rst_n(rst_n), .char_code(char_code),
        .end_of_text(end_of_text), .in_valid(in_valid), .in_ready(in_ready),
        .q_data(q_data), .q_valid(q_valid), .q_ready(q_ready)
    );

    // back: parse state and result burst
    fpp_back u_back (
        .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid),
        .q_ready(q_ready), .piece_index(piece_index), .piece_board(piece_board),
        .side_to_move(side_to_move), .castling_rights(castling_rights),
        .ep_present(ep_present), .ep_square(ep_square),
        .halfmove_count(halfmove_count), .fullmove_count(fullmove_count),
        .valid_res(valid_res), .last(last), .out_valid(out_valid),
        .out_ready(out_ready)
    );

`ifndef SYNTH
    // an invalid result is always a single last beat
    a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> last)
        else $error("invalid result not last");
    // a good result never carries a piece index past the table
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> piece_index < 4'd12)
        else $error("piece index out of range");
    // a stalled result beat keeps its piece index
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(piece_index))
        else $error("result beat changed under stall");
`endif
endmodule
`default_nettype wire

@@ tb/sv/fen_position_parser_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fen_position_parser_tb;
    import fpp_pkg::*;

    // watchdog bound on simulated cycles
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [3:0]  idx;
        logic [63:0] board;
        logic        side;
        logic [3:0]  castle;
        logic        ep_on;
        logic [5:0]  ep_sq;
        logic [COUNTER_BITS-1:0] half;
        logic [COUNTER_BITS-1:0] full;
        logic        ok;
        logic        fin;
    } res_t;

    logic clk;
    logic rst_n;
    logic [7:0] char_code;
    logic end_of_text;
    logic in_valid;
    logic in_ready;
    logic [3:0] piece_index;
    logic [63:0] piece_board;
    logic side_to_move;
    logic [3:0] castling_rights;
    logic ep_present;
    logic [5:0] ep_square;
    logic [COUNTER_BITS-1:0] halfmove_count;
    logic [COUNTER_BITS-1:0] fullmove_count;
    logic valid_res;
    logic last;
    logic out_valid;
    logic out_ready;

    fen_position_parser DUT (
        .clk(clk), .rst_n(rst_n), .char_code(char_code), .end_of_text(end_of_text),
        .in_valid(in_valid), .in_ready(in_ready), .piece_index(piece_index),
        .piece_board(piece_board), .side_to_move(side_to_move),
        .castling_rights(castling_rights), .ep_present(ep_present),
        .ep_square(ep_square), .halfmove_count(halfmove_count),
        .fullmove_count(fullmove_count), .valid_res(valid_res), .last(last),
        .out_valid(out_valid), .out_ready(out_ready)
    );

    // clock, 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // predictor state, mirrors the parser
    phase_t      pr_phase;
    int unsigned pr_file;
    int unsigned pr_rank;
    logic [63:0] pr_boards [12];
    logic        pr_turn;
    logic [3:0]  pr_castle;
    logic        pr_ep_on;
    logic [5:0]  pr_ep_sq;
    logic [COUNTER_BITS-1:0] pr_half;
    logic [COUNTER_BITS-1:0] pr_full;
    logic        pr_digit;
    logic        pr_err;

    res_t expected_results[$];
    int   mismatches;
    int   results_seen;
    int   texts_sent;
    int   bad_texts;
    longint cycles;
    bit   no_idle;

    task automatic clear_parse();
        pr_phase = PH_BOARD;
        pr_file = 0;
        pr_rank = 7;
        for (int k = 0; k < 12; k++)
            pr_boards[k] = '0;
        pr_turn = 0;
        pr_castle = 0;
        pr_ep_on = 0;
        pr_ep_sq = 0;
        pr_half = 0;
        pr_full = 0;
        pr_digit = 0;
        pr_err = 0;
    endtask

    function automatic int piece_of(input logic [7:0] c);
        case (c)
            "K": return 0;
            "Q": return 1;
            "R": return 2;
            "B": return 3;
            "N": return 4;
            "P": return 5;
            "k": return 6;
            "q": return 7;
            "r": return 8;
            "b": return 9;
            "n": return 10;
            "p": return 11;
            default: return -1;
        endcase
    endfunction

    // decimal accumulate, saturating at the counter width
    function automatic logic [COUNTER_BITS-1:0] count_up(input logic [COUNTER_BITS-1:0] acc,
                                                        input logic [7:0] c);
        longint v;
        v = longint'(acc) * 10 + longint'(c - CH_ZERO);
        if (v > ((64'd1 << COUNTER_BITS) - 1))
            v = (64'd1 << COUNTER_BITS) - 1;
        return v[COUNTER_BITS-1:0];
    endfunction

    task automatic parse_counter(input logic [7:0] c, input bit is_full);
        if (c == CH_SPACE)
        begin
            if (!pr_digit)
                return;
            if (is_full)
            begin
                pr_err = 1;
                return;
            end
            pr_digit = 0;
            pr_phase = PH_FULL;
        end
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (is_full)
                pr_full = count_up(pr_full, c);
            else
                pr_half = count_up(pr_half, c);
            pr_digit = 1;
        end
        else
            pr_err = 1;
    endtask

    task automatic parse_byte(input logic [7:0] c);
        int p;
        int unsigned f;
        case (pr_phase)
            PH_BOARD:
            begin
                p = piece_of(c);
                if (c >= CH_ONE && c <= CH_EIGHT)
                begin
                    f = pr_file + (c - CH_ZERO);
                    if (f > 8)
                        pr_err = 1;
                    else
                        pr_file = f;
                end
                else if (c == CH_SPACE)
                begin
                    if (pr_file == 8)
                        pr_phase = PH_TURN;
                    else if (!(pr_file == 0 && pr_rank == 7))
                        pr_err = 1;
                end
                else if (c == CH_SLASH)
                begin
                    if (pr_file != 8 || pr_rank == 0)
                        pr_err = 1;
                    else
                    begin
                        pr_file = 0;
                        pr_rank--;
                    end
                end
                else if (p >= 0)
                begin
                    if (pr_file >= 8)
                        pr_err = 1;
                    else
                    begin
                        pr_boards[p][pr_rank * 8 + pr_file] = 1'b1;
                        pr_file++;
                    end
                end
                else
                    pr_err = 1;
            end
            PH_TURN:
            begin
                if (c == CH_W || c == CH_B)
                begin
                    pr_turn = (c == CH_B);
                    pr_phase = PH_CASTLE_START;
                end
                else if (c != CH_SPACE)
                    pr_err = 1;
            end
            PH_CASTLE_START, PH_CASTLE_BODY:
            begin
                if (c == CH_SPACE)
                begin
                    if (pr_phase == PH_CASTLE_BODY)
                        pr_phase = PH_EP_FIRST;
                end
                else if (c == CH_DASH)
                    pr_phase = PH_EP_FIRST;
                else if (c == "K" || c == "Q" || c == "k" || c == "q")
                begin
                    pr_castle[(c == "K") ? 0 : (c == "Q") ? 1 : (c == "k") ? 2 : 3] = 1'b1;
                    pr_phase = PH_CASTLE_BODY;
                end
                else
                    pr_err = 1;
            end
            PH_EP_FIRST:
            begin
                if (c == CH_DASH)
                begin
                    pr_ep_on = 0;
                    pr_phase = PH_HALF;
                end
                else if (c >= CH_A && c <= CH_H)
                begin
                    pr_ep_sq = 6'(c - CH_A);
                    pr_phase = PH_EP_SECOND;
                end
                else if (c != CH_SPACE)
                    pr_err = 1;
            end
            PH_EP_SECOND:
            begin
                if (c < CH_ONE || c > CH_EIGHT)
                    pr_err = 1;
                else
                begin
                    pr_ep_sq = 6'((c - CH_ONE) * 8 + pr_ep_sq[2:0]);
                    pr_ep_on = 1;
                    pr_phase = PH_HALF;
                end
            end
            PH_HALF:
                parse_counter(c, 0);
            default:
                parse_counter(c, 1);
        endcase
    endtask

    // end beat: queue the twelve boards or the single error beat
    task automatic finish_text();
        res_t r;
        texts_sent++;
        if (pr_err || pr_phase != PH_FULL || !pr_digit)
        begin
            r = '0;
            r.fin = 1;
            expected_results.push_back(r);
            bad_texts++;
        end
        else
        begin
            for (int k = 0; k < 12; k++)
            begin
                r.idx = 4'(k);
                r.board = pr_boards[k];
                r.side = pr_turn;
                r.castle = pr_castle;
                r.ep_on = pr_ep_on;
                r.ep_sq = pr_ep_on ? pr_ep_sq : 6'd0;
                r.half = pr_half;
                r.full = pr_full;
                r.ok = 1;
                r.fin = (k == 11);
                expected_results.push_back(r);
            end
        end
        clear_parse();
    endtask

    // one input beat, waits for the handshake; idles before it at random
    task automatic send_beat(input logic [7:0] c, input logic eot);
        while (!no_idle && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        char_code <= c;
        end_of_text <= eot;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (eot)
            finish_text();
        else if (!pr_err)
            parse_byte(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
        send_beat(8'($urandom), 1'b1);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random stalls, compare each beat with the oldest expectation
    always @(posedge clk)
    begin
        res_t want;
        res_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {piece_index, piece_board, side_to_move, castling_rights, ep_present,
                       ep_square, halfmove_count, fullmove_count, valid_res, last};
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            out_ready <= no_idle || ($urandom_range(99) >= 12);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        int n;
        n = 0;
        while (expected_results.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    function automatic string rank_text(input bit ok_len);
        string s;
        int f;
        string letters;
        letters = "KQRBNPkqrbnp";
        s = "";
        f = 0;
        while (f < 8)
        begin
            if ($urandom_range(1))
            begin
                int g;
                g = $urandom_range(8 - f, 1);
                s = {s, string'(8'(CH_ZERO + g))};
                f += g;
            end
            else
            begin
                s = {s, string'(letters[$urandom_range(11)])};
                f++;
            end
        end
        if (!ok_len)
        begin
            if ($urandom_range(1))
                s = {s, "p"};
            else
                s = {s, "1"};
        end
        return s;
    endfunction

    function automatic string num_text();
        string s;
        int n;
        s = "";
        n = ($urandom_range(9) == 0) ? $urandom_range(9, 5) : $urandom_range(3, 1);
        for (int i = 0; i < n; i++)
            s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
        return s;
    endfunction

    // a well-formed text with random content
    function automatic string good_text();
        string s;
        int nr;
        string castle_letters;
        castle_letters = "KQkq";
        nr = $urandom_range(8, 1);
        s = "";
        for (int r = 0; r < nr; r++)
        begin
            if (r != 0)
                s = {s, "/"};
            s = {s, rank_text(1)};
        end
        if ($urandom_range(1))
            s = {s, " w "};
        else
            s = {s, " b "};
        if ($urandom_range(3) == 0)
            s = {s, "-"};
        else
            for (int i = 0; i < 4; i++)
                if ($urandom_range(1))
                    s = {s, string'(castle_letters[i])};
        if (s[s.len()-1] == " ")
            s = {s, "-"};
        s = {s, " "};
        if ($urandom_range(1))
            s = {s, "-"};
        else
            s = {s, string'(8'(CH_A + $urandom_range(7))),
                 string'(8'(CH_ONE + $urandom_range(7)))};
        s = {s, " ", num_text(), " ", num_text()};
        return s;
    endfunction

    task automatic test_directed();
        send_text("rnbqkbnr/pppppppp/8/8/8/8/PPPPPPPP/RNBQKBNR w KQkq - 0 1");
        send_text("  8   b   Kq   h8  99999  65535");
        send_text("4k3/4K3 w - a1 12 5");
        send_text("8/8/8/8/8/8/8/8/8 w - - 0 1");
        send_text("7/8 w - - 0 1");
        send_text("9/8 w - - 0 1");
        send_text("ppppppppp w - - 0 1");
        send_text("8 w - - +1 1");
        send_text("8 w - - 1 1 ");
        send_text("8 w - - 1 ");
        send_text("8 x - - 1 1");
        send_text("8 w - i3 1 1");
        send_text("8 w - a9 1 1");
        send_text("8 w Z - 1 1");
        send_text("0 w - - 1 1");
        send_text("");
        send_beat(8'hff, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b1);
        send_text("8 w - - 7 8x");
        send_text("KQRBNPkq/rbnp4 b - e3 3 70000");
    endtask

    // pause the sender until every result is back
    task automatic test_drain_pause();
        drop_valid();
        wait_drained();
        send_text(good_text());
    endtask

    task automatic test_random(input int total);
        int sent;
        string s;
        int pick;
        sent = 0;
        while (sent < total)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                s = good_text();
            else if (pick < 85)
            begin
                s = good_text();
                s[$urandom_range(s.len() - 1)] = 8'($urandom);
            end
            else if (pick < 93)
                s = {rank_text(0), " w - - 1 1"};
            else
            begin
                s = "";
                for (int i = 0; i < $urandom_range(6); i++)
                    s = {s, string'(8'($urandom))};
            end
            no_idle = (sent >= total / 2);
            send_text(s);
            sent += s.len() + 1;
        end
        no_idle = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_code = '0;
        end_of_text = 1'b0;
        out_ready = 1'b0;
        mismatches = 0;
        results_seen = 0;
        texts_sent = 0;
        bad_texts = 0;
        cycles = 0;
        no_idle = 0;
        clear_parse();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_drain_pause();
        test_random(80);
        drop_valid();
        wait_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d texts (%0d rejected), %0d result beats checked",
                 texts_sent, bad_texts, results_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
